// ===== design/qdom_pkg.sv =====
// Package with the beat types, codes and helper functions of the order matcher.
`timescale 1ns / 1ps
package qdom_pkg;

    localparam int SymbolCountDefault = 16;
    localparam int TableDepthDefault  = 64;

    typedef enum logic [1:0] {
        OP_QUOTE  = 2'd0,
        OP_NEW    = 2'd1,
        OP_CANCEL = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    localparam logic [2:0] KIND_ACK      = 3'd0;
    localparam logic [2:0] KIND_FILL     = 3'd1;
    localparam logic [2:0] KIND_NOCP     = 3'd2;
    localparam logic [2:0] KIND_CANCELED = 3'd3;
    localparam logic [2:0] KIND_CXLREJ   = 3'd4;
    localparam logic [2:0] KIND_FULL     = 3'd5;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  symbol;
        logic [31:0] client_id;
        logic [31:0] target_id;
        logic        side;
        logic        order_kind;
        logic [30:0] limit_price;
        logic [31:0] quantity;
        logic [30:0] bid_price;
        logic [31:0] bid_volume;
        logic [30:0] ask_price;
        logic [31:0] ask_volume;
    } t_in;

    typedef struct packed {
        logic [31:0] report_client_id;
        logic [31:0] report_target_id;
        logic [31:0] engine_order_number;
        logic [31:0] exec_number;
        logic [2:0]  report_kind;
        logic        report_side;
        logic        report_order_kind;
        logic [30:0] report_price;
        logic [31:0] report_quantity;
        logic [30:0] fill_price;
        logic        last_report;
    } t_out;

    typedef struct packed {
        logic [3:0]  symbol;
        logic [31:0] client_id;
        logic        side;
        logic [30:0] price;
        logic [31:0] quantity;
        logic [31:0] number;
    } t_entry;

    function automatic logic can_fill(input logic side, input logic market,
                                      input logic [30:0] price,
                                      input logic [30:0] bid_px, input logic [31:0] bid_vol,
                                      input logic [30:0] ask_px, input logic [31:0] ask_vol);
        logic ok;
        if (!side) begin
            ok = (ask_vol != 32'd0) && (market || price >= ask_px);
        end else begin
            ok = (bid_vol != 32'd0) && (market || price <= bid_px);
        end
        return ok;
    endfunction

endpackage

// ===== design/qdom_front.sv =====
// Front end: accepts input beats, drops ignored ones and queues the rest.
`timescale 1ns / 1ps
module qdom_front #(
    parameter int SYMBOL_COUNT = qdom_pkg::SymbolCountDefault
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  qdom_pkg::t_in  i_in,
    output logic           o_cmd_valid,
    output qdom_pkg::t_in  o_cmd,
    input  logic           i_cmd_pop
);

    qdom_pkg::t_in r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       keep;
    logic       push;
    logic       pop;

    assign o_in_stall  = (r_cnt == 2'd2);
    assign keep        = (i_in.operation != qdom_pkg::OP_NONE) &&
                         (32'(i_in.symbol) < 32'(SYMBOL_COUNT));
    assign push        = i_in_valid && !o_in_stall && keep;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign pop         = o_cmd_valid && i_cmd_pop;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_in;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== design/qdom_back.sv =====
// Back end: quote store, resting order table, scan sequencer and report register.
`timescale 1ns / 1ps
module qdom_back #(
    parameter int SYMBOL_COUNT = qdom_pkg::SymbolCountDefault,
    parameter int TABLE_DEPTH  = qdom_pkg::TableDepthDefault
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  qdom_pkg::t_in  i_cmd,
    output logic           o_cmd_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output qdom_pkg::t_out o_out,
    output logic           o_busy,
    output logic           o_ptr_ok,
    output logic           o_count_ok
);

    localparam int QD = (SYMBOL_COUNT < 16) ? SYMBOL_COUNT : 16;
    localparam int QW = (QD > 1) ? $clog2(QD) : 1;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RD   = 3'b010,
        S_EV   = 3'b100
    } t_state;

    qdom_pkg::t_entry r_mem [TABLE_DEPTH];
    qdom_pkg::t_entry r_rdata;
    logic [30:0] r_bpx [QD];
    logic [31:0] r_bvol [QD];
    logic [30:0] r_apx [QD];
    logic [31:0] r_avol [QD];

    t_state r_state, n_state;
    qdom_pkg::t_in r_cmd, n_cmd;
    logic [CW-1:0] r_rd, n_rd, r_w, n_w, r_count, n_count;
    logic r_found, n_found, r_pend_v, n_pend_v;
    qdom_pkg::t_out r_pend, n_pend;
    logic [31:0] r_seq, r_oseq, n_oseq;
    logic r_out_v;
    qdom_pkg::t_out r_out;

    logic free, load, re, we, qwe;
    qdom_pkg::t_out ld;
    logic [AW-1:0] wa;
    qdom_pkg::t_entry wd;
    logic [QW-1:0] hq, cq;
    logic hfill, ematch;
    qdom_pkg::t_out erep;

    assign free = !r_out_v || !i_out_stall;
    assign hq   = i_cmd.symbol[QW-1:0];
    assign cq   = r_cmd.symbol[QW-1:0];
    assign hfill = qdom_pkg::can_fill(i_cmd.side, i_cmd.order_kind, i_cmd.limit_price,
                                      r_bpx[hq], r_bvol[hq], r_apx[hq], r_avol[hq]);

    always_comb begin
        erep = '0;
        if (r_cmd.operation == qdom_pkg::OP_QUOTE) begin
            ematch = (r_rdata.symbol == r_cmd.symbol) &&
                     qdom_pkg::can_fill(r_rdata.side, 1'b0, r_rdata.price,
                                        r_bpx[cq], r_bvol[cq], r_apx[cq], r_avol[cq]);
            erep.report_client_id = r_rdata.client_id;
            erep.report_kind      = qdom_pkg::KIND_FILL;
            erep.fill_price       = r_rdata.side ? r_bpx[cq] : r_apx[cq];
        end else begin
            ematch = !r_found && (r_rdata.symbol == r_cmd.symbol) &&
                     (r_rdata.client_id == r_cmd.target_id);
            erep.report_client_id = r_cmd.client_id;
            erep.report_target_id = r_cmd.target_id;
            erep.report_kind      = qdom_pkg::KIND_CANCELED;
        end
        erep.engine_order_number = r_rdata.number;
        erep.report_side         = r_rdata.side;
        erep.report_price        = r_rdata.price;
        erep.report_quantity     = r_rdata.quantity;
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_rd     = r_rd;
        n_w      = r_w;
        n_count  = r_count;
        n_found  = r_found;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_oseq   = r_oseq;
        o_cmd_pop = 1'b0;
        load = 1'b0;
        ld   = '0;
        re   = 1'b0;
        we   = 1'b0;
        qwe  = 1'b0;
        wa   = r_count[AW-1:0];
        wd   = r_rdata;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.operation)
                        qdom_pkg::OP_NEW: begin
                            if (free) begin
                                o_cmd_pop = 1'b1;
                                n_oseq = r_oseq + 32'd1;
                                load = 1'b1;
                                ld.report_client_id    = i_cmd.client_id;
                                ld.engine_order_number = r_oseq;
                                ld.report_side         = i_cmd.side;
                                ld.report_order_kind   = i_cmd.order_kind;
                                ld.report_price        = i_cmd.limit_price;
                                ld.report_quantity     = i_cmd.quantity;
                                ld.last_report         = 1'b1;
                                if (hfill) begin
                                    ld.report_kind = qdom_pkg::KIND_FILL;
                                    ld.fill_price  = i_cmd.side ? r_bpx[hq] : r_apx[hq];
                                end else if (i_cmd.order_kind) begin
                                    ld.report_kind = qdom_pkg::KIND_NOCP;
                                end else if (32'(r_count) >= 32'(TABLE_DEPTH)) begin
                                    ld.report_kind = qdom_pkg::KIND_FULL;
                                end else begin
                                    ld.report_kind = qdom_pkg::KIND_ACK;
                                    we = 1'b1;
                                    wd.symbol    = i_cmd.symbol;
                                    wd.client_id = i_cmd.client_id;
                                    wd.side      = i_cmd.side;
                                    wd.price     = i_cmd.limit_price;
                                    wd.quantity  = i_cmd.quantity;
                                    wd.number    = r_oseq;
                                    n_count = r_count + CW'(1);
                                end
                            end
                        end
                        qdom_pkg::OP_QUOTE, qdom_pkg::OP_CANCEL: begin
                            o_cmd_pop = 1'b1;
                            qwe = (i_cmd.operation == qdom_pkg::OP_QUOTE);
                            n_cmd = i_cmd;
                            n_rd = '0;
                            n_w = '0;
                            n_found = 1'b0;
                            n_pend_v = 1'b0;
                            n_state = S_RD;
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_RD: begin
                if (r_rd == r_count) begin
                    if (r_cmd.operation == qdom_pkg::OP_CANCEL && !r_found) begin
                        if (free) begin
                            load = 1'b1;
                            ld.report_client_id = r_cmd.client_id;
                            ld.report_target_id = r_cmd.target_id;
                            ld.report_kind      = qdom_pkg::KIND_CXLREJ;
                            ld.last_report      = 1'b1;
                            n_state = S_IDLE;
                        end
                    end else if (r_pend_v) begin
                        if (free) begin
                            load = 1'b1;
                            ld = r_pend;
                            ld.last_report = 1'b1;
                            n_pend_v = 1'b0;
                            n_count = r_w;
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_count = r_w;
                        n_state = S_IDLE;
                    end
                end else begin
                    re = 1'b1;
                    n_state = S_EV;
                end
            end
            S_EV: begin
                if (ematch) begin
                    if (!r_pend_v || free) begin
                        if (r_pend_v) begin
                            load = 1'b1;
                            ld = r_pend;
                        end
                        n_pend   = erep;
                        n_pend_v = 1'b1;
                        n_found  = 1'b1;
                        n_rd     = r_rd + CW'(1);
                        n_state  = S_RD;
                    end
                end else begin
                    we = 1'b1;
                    wa = r_w[AW-1:0];
                    n_w = r_w + CW'(1);
                    n_rd = r_rd + CW'(1);
                    n_state = S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        ld.exec_number = r_seq;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (re) begin
            r_rdata <= r_mem[r_rd[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_rd   <= n_rd;
        r_w    <= n_w;
        r_found <= n_found;
        r_pend <= n_pend;
        if (load) begin
            r_out <= ld;
        end
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pend_v <= 1'b0;
            r_seq    <= '0;
            r_oseq   <= '0;
            r_out_v  <= 1'b0;
            for (int k = 0; k < QD; k++) begin
                r_bpx[k]  <= '0;
                r_bvol[k] <= '0;
                r_apx[k]  <= '0;
                r_avol[k] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend_v <= n_pend_v;
            r_oseq   <= n_oseq;
            if (load) begin
                r_seq   <= r_seq + 32'd1;
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
            if (qwe) begin
                r_bpx[hq]  <= i_cmd.bid_price;
                r_bvol[hq] <= i_cmd.bid_volume;
                r_apx[hq]  <= i_cmd.ask_price;
                r_avol[hq] <= i_cmd.ask_volume;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;
    assign o_busy      = (r_state != S_IDLE) || r_pend_v;
    assign o_ptr_ok    = (r_w <= r_rd) && (r_rd <= r_count);
    assign o_count_ok  = (32'(r_count) <= 32'(TABLE_DEPTH));

endmodule

// ===== design/quote_driven_order_matcher.sv =====
// Top level of the quote-driven order matcher.
// A new order's report is registered from the queue head once the output register is free,
// so it passes the two-entry front queue and the report register before it is offered.
// A quote update or cancel holds the back end while the table scan runs over the N resting
// orders, a read state then an evaluate state per entry; output stalls lengthen it.
// Reset is synchronous: quotes clear to empty, the table count and sequence numbers to zero.
// The resting table memory is not cleared; only entries below the fill count are read.
`timescale 1ns / 1ps
module quote_driven_order_matcher #(
    parameter int SYMBOL_COUNT = qdom_pkg::SymbolCountDefault,
    parameter int TABLE_DEPTH  = qdom_pkg::TableDepthDefault
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  qdom_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output qdom_pkg::t_out o_out
);

    logic          cmd_valid;
    qdom_pkg::t_in cmd;
    logic          cmd_pop;
    logic          busy;
    logic          ptr_ok;
    logic          count_ok;

    qdom_front #(.SYMBOL_COUNT(SYMBOL_COUNT)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    qdom_back #(.SYMBOL_COUNT(SYMBOL_COUNT), .TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .o_busy      (busy),
        .o_ptr_ok    (ptr_ok),
        .o_count_ok  (count_ok)
    );

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n) count_ok)
        else $error("Resting count exceeds table depth.");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n) busy |-> ptr_ok)
        else $error("Scan pointers out of order.");
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_pop && cmd.operation == qdom_pkg::OP_QUOTE) |=> busy)
        else $error("Quote beat did not start a scan.");

endmodule
